>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the region table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vrt_pkg.sv
// Package with the codes and constants of the region table.
`default_nettype none
package vrt_pkg;
  localparam int unsigned MaxRegionsDef = 16;
  localparam int unsigned PageShiftDef  = 12;

  localparam logic [1:0] ReqInsert = 2'd0;
  localparam logic [1:0] ReqLookup = 2'd1;
  localparam logic [1:0] ReqFault  = 2'd2;
  localparam logic [1:0] ReqClear  = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoReg   = 3'd1;
  localparam logic [2:0] StDenied  = 3'd2;
  localparam logic [2:0] StBadRng  = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  localparam logic [1:0] FcReadPresent = 2'd1;
  localparam logic [1:0] FcReadAbsent  = 2'd0;
endpackage
`default_nettype wire

>>> rtl/vrt_table.sv
// Region storage memory: one write port and one registered read port.
`default_nettype none
module vrt_table #(
  parameter int unsigned MaxRegions = vrt_pkg::MaxRegionsDef,
  localparam int unsigned IdxW = $clog2(MaxRegions)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [66:0]     wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic      [66:0]     rdata_o
);
  logic [66:0] mem_q [MaxRegions];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/vma_region_table_fault_check.sv
// Lookup and fault check try the cached last-hit entry first, then scan from slot 0;
// clear empties the table without a scan. Insert scans for its slot, then shifts the
// entries above it up one slot from the top down (an append shifts nothing).
// One table read port sets the pace: entries are read and checked one at a time.
// One transaction is in flight at a time; its result waits in an output register.
// Reset empties the table and the last-hit cache; region contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module vma_region_table_fault_check import vrt_pkg::*; #(
  parameter int unsigned MaxRegions = MaxRegionsDef,
  parameter int unsigned PageShift  = PageShiftDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [31:0] range_end_i,
  input  wire logic [2:0]  access_flags_i,
  input  wire logic [1:0]  fault_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic             hit_o,
  output logic [31:0]      found_start_o,
  output logic [31:0]      found_end_o,
  output logic [2:0]       found_flags_o,
  output logic [2:0]       page_perm_o,
  output logic [31:0]      page_base_o
);
  localparam int unsigned IdxW = $clog2(MaxRegions);
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SShRd  = 3'd3;
  localparam logic [2:0] SShWr  = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] lh_idx_q, lh_idx_d;
  logic lh_valid_q, lh_valid_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic cache_q, cache_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [1:0] req_q;
  logic [31:0] addr_q, end_q;
  logic [2:0] flags_q;
  logic [1:0] fc_q;
  logic [31:0] prev_end_q, prev_end_d;

  logic out_valid_q, out_valid_d;
  logic [2:0] st_q, st_d;
  logic hit_q, hit_d;
  logic [31:0] fs_q, fs_d, fe_q, fe_d, pb_q, pb_d;
  logic [2:0] ff_q, ff_d, pp_q, pp_d;

  logic res_load;
  logic [2:0] res_st_q, res_ff_q, res_pp_q;
  logic res_hit_q;
  logic [31:0] res_fs_q, res_fe_q, res_pb_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [66:0] wdata, rdata;
  logic [31:0] r_start, r_end;
  logic [2:0] r_flags;
  logic contains, ok;
  logic in_acc;

  vrt_table #(.MaxRegions(MaxRegions)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign r_start  = rdata[66:35];
  assign r_end    = rdata[34:3];
  assign r_flags  = rdata[2:0];
  assign contains = (r_start <= addr_q) && (addr_q < r_end);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    case (fc_q)
      FcReadPresent: ok = 1'b0;
      FcReadAbsent:  ok = r_flags[0] || r_flags[2];
      default:       ok = r_flags[1];
    endcase
  end

  always_comb begin
    state_d = state_q;  count_d = count_q;  lh_idx_d = lh_idx_q;
    lh_valid_d = lh_valid_q;  ptr_d = ptr_q;  cache_d = cache_q;
    pos_d = pos_q;  prev_end_d = prev_end_q;
    out_valid_d = out_valid_q && out_stall_i;
    st_d = st_q;  hit_d = hit_q;  fs_d = fs_q;  fe_d = fe_q;
    ff_d = ff_q;  pp_d = pp_q;  pb_d = pb_q;
    res_load = 1'b0;
    we = 1'b0;  waddr = '0;  wdata = '0;  raddr = ptr_q[IdxW-1:0];
    case (state_q)
      SIdle: begin
        if (in_acc) begin
          ptr_d = '0;  pos_d = '0;  prev_end_d = '0;
          cache_d = (req_type_i != ReqInsert) && lh_valid_q
                    && (CntW'(lh_idx_q) < count_q);
          if (cache_d) ptr_d = CntW'(lh_idx_q);
          state_d = SRead;
        end
      end
      SRead: begin
        // The table read issued with ptr_q returns on the next cycle.
        state_d = SCheck;
        st_d = StOk;  hit_d = 1'b0;  fs_d = '0;  fe_d = '0;
        ff_d = '0;  pp_d = '0;  pb_d = '0;
        if (req_q == ReqClear) begin
          count_d = '0;  lh_idx_d = '0;  lh_valid_d = 1'b0;
          state_d = SDone;
        end else if (req_q == ReqInsert) begin
          if (addr_q >= end_q) begin
            st_d = StBadRng;  state_d = SDone;
          end else if (ptr_q >= count_q) begin
            pos_d = ptr_q;
            if (ptr_q != '0 && prev_end_q > addr_q) begin
              st_d = StBadRng;  state_d = SDone;
            end else if (count_q >= CntW'(MaxRegions)) begin
              st_d = StFull;  state_d = SDone;
            end else begin
              ptr_d = count_q;  state_d = SShRd;
            end
          end
        end else if (!cache_q && ptr_q >= count_q) begin
          st_d = StNoReg;  state_d = SDone;
        end
      end
      SCheck: begin
        state_d = SRead;
        if (req_q == ReqInsert) begin
          if (r_start <= addr_q) begin
            prev_end_d = r_end;  ptr_d = ptr_q + 1'b1;
          end else begin
            pos_d = ptr_q;
            if ((ptr_q != '0 && prev_end_q > addr_q) || r_start < end_q) begin
              st_d = StBadRng;  state_d = SDone;
            end else if (count_q >= CntW'(MaxRegions)) begin
              st_d = StFull;  state_d = SDone;
            end else begin
              ptr_d = count_q;  state_d = SShRd;
            end
          end
        end else if (contains) begin
          hit_d = 1'b1;  fs_d = r_start;  fe_d = r_end;  ff_d = r_flags;
          lh_idx_d = ptr_q[IdxW-1:0];  lh_valid_d = 1'b1;
          if (req_q == ReqFault) begin
            if (ok) begin
              pp_d = {1'b1, r_flags[1], 1'b0};
              pb_d = {addr_q[31:PageShift], {PageShift{1'b0}}};
            end else begin
              st_d = StDenied;
            end
          end
          state_d = SDone;
        end else begin
          if (cache_q) ptr_d = '0;
          else ptr_d = ptr_q + 1'b1;
          cache_d = 1'b0;
        end
      end
      SShRd: begin
        // Move entries up one slot from the top down to the insert point.
        if (ptr_q == pos_q) begin
          we = 1'b1;  waddr = pos_q[IdxW-1:0];
          wdata = {addr_q, end_q, flags_q};
          count_d = count_q + 1'b1;
          if (lh_valid_q && CntW'(lh_idx_q) >= pos_q) lh_idx_d = lh_idx_q + 1'b1;
          state_d = SDone;
        end else begin
          raddr = IdxW'(ptr_q - 1'b1);
          state_d = SShWr;
        end
      end
      SShWr: begin
        we = 1'b1;  waddr = ptr_q[IdxW-1:0];  wdata = rdata;
        ptr_d = ptr_q - 1'b1;  state_d = SShRd;
      end
      SDone: begin
        // The finished result moves to the output register once that register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;  res_load = 1'b1;  state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;  count_q <= '0;  lh_idx_q <= '0;
      lh_valid_q <= 1'b0;  out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  count_q <= count_d;  lh_idx_q <= lh_idx_d;
      lh_valid_q <= lh_valid_d;  out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;  cache_q <= cache_d;  pos_q <= pos_d;
    prev_end_q <= prev_end_d;
    st_q <= st_d;  hit_q <= hit_d;  fs_q <= fs_d;  fe_q <= fe_d;
    ff_q <= ff_d;  pp_q <= pp_d;  pb_q <= pb_d;
    if (in_acc) begin
      req_q <= req_type_i;  addr_q <= addr_i;  end_q <= range_end_i;
      flags_q <= access_flags_i;  fc_q <= fault_code_i;
    end
    if (res_load) begin
      res_st_q <= st_q;  res_hit_q <= hit_q;  res_fs_q <= fs_q;  res_fe_q <= fe_q;
      res_ff_q <= ff_q;  res_pp_q <= pp_q;  res_pb_q <= pb_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_st_q;
  assign hit_o         = res_hit_q;
  assign found_start_o = res_fs_q;
  assign found_end_o   = res_fe_q;
  assign found_flags_o = res_ff_q;
  assign page_perm_o   = res_pp_q;
  assign page_base_o   = res_pb_q;

  `ASSERT_CLK(a_count_range, clk_i, rst_ni, count_q <= CntW'(MaxRegions), "count overflow")
  `ASSERT_CLK(a_hit_status, clk_i, rst_ni,
              !out_valid_q || res_hit_q || (res_pp_q == '0 && res_pb_q == '0),
              "page fields without hit")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, in_stall_o, "accepted while busy")
  `ASSERT_CLK(a_cache_idx, clk_i, rst_ni,
              !lh_valid_q || (CntW'(lh_idx_q) < count_q), "cache index past count")
endmodule
`default_nettype wire

>>> verif/vma_region_table_fault_check_checker.sv
// Checker that predicts and compares the results of the region table.
`timescale 1ns / 100ps
`default_nettype none
module vma_region_table_fault_check_checker import vrt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] addr_i,
  input  wire logic [31:0] range_end_i,
  input  wire logic [2:0]  access_flags_i,
  input  wire logic [1:0]  fault_code_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  status_i,
  input  wire logic        hit_i,
  input  wire logic [31:0] found_start_i,
  input  wire logic [31:0] found_end_i,
  input  wire logic [2:0]  found_flags_i,
  input  wire logic [2:0]  page_perm_i,
  input  wire logic [31:0] page_base_i,
  output int               fail_count_o,
  output int               pending_o
);
  localparam int unsigned Depth = MaxRegionsDef;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [31:0] found_start;
    logic [31:0] found_end;
    logic [2:0]  found_flags;
    logic [2:0]  page_perm;
    logic [31:0] page_base;
  } region_result_t;

  logic [31:0] tbl_start [Depth];
  logic [31:0] tbl_end [Depth];
  logic [2:0]  tbl_flags [Depth];
  int unsigned tbl_count;
  int unsigned cache_idx;
  bit          cache_ok;
  region_result_t expected_results[$];

  // Returns the containing index or -1; refreshes the cache only on a scan hit.
  function automatic int find_region(logic [31:0] a);
    if (cache_ok && cache_idx < tbl_count && tbl_start[cache_idx] <= a &&
        a < tbl_end[cache_idx]) return cache_idx;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= a && a < tbl_end[i]) begin
        cache_idx = i;
        cache_ok = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [2:0] insert_region(logic [31:0] s, logic [31:0] e,
                                               logic [2:0] f);
    int unsigned pos;
    pos = 0;
    if (s >= e) return StBadRng;
    while (pos < tbl_count && tbl_start[pos] <= s) pos++;
    if (pos > 0 && tbl_end[pos-1] > s) return StBadRng;
    if (pos < tbl_count && tbl_start[pos] < e) return StBadRng;
    if (tbl_count >= Depth) return StFull;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_end[i] = tbl_end[i-1];
      tbl_flags[i] = tbl_flags[i-1];
    end
    tbl_start[pos] = s;
    tbl_end[pos] = e;
    tbl_flags[pos] = f;
    tbl_count++;
    if (cache_ok && cache_idx >= pos) cache_idx++;
    return StOk;
  endfunction

  function automatic region_result_t predict_request(logic [1:0] req, logic [31:0] a,
                                                     logic [31:0] e, logic [2:0] f,
                                                     logic [1:0] code);
    region_result_t r;
    int idx;
    logic [2:0] fl;
    bit ok;
    r = '0;
    if (req == ReqInsert) begin
      r.status = insert_region(a, e, f);
      return r;
    end
    if (req == ReqClear) begin
      tbl_count = 0;
      cache_idx = 0;
      cache_ok = 1'b0;
      return r;
    end
    idx = find_region(a);
    if (idx < 0) begin
      r.status = StNoReg;
      return r;
    end
    fl = tbl_flags[idx];
    r.hit = 1'b1;
    r.found_start = tbl_start[idx];
    r.found_end = tbl_end[idx];
    r.found_flags = fl;
    if (req == ReqLookup) return r;
    if (code == FcReadPresent) ok = 1'b0;
    else if (code == FcReadAbsent) ok = (fl & 3'b101) != 0;
    else ok = fl[1];
    if (!ok) begin
      r.status = StDenied;
      return r;
    end
    r.page_perm = {1'b1, fl[1], 1'b0};
    r.page_base = {a[31:PageShiftDef], {PageShiftDef{1'b0}}};
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    region_result_t exp_r;
    if (!rst_ni) begin
      tbl_count = 0;
      cache_idx = 0;
      cache_ok = 1'b0;
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != {status_i, hit_i, found_start_i, found_end_i, found_flags_i,
                        page_perm_i, page_base_i}) begin
            fail_count_o <= fail_count_o + 1;
            if (exp_r.status != status_i)
              $error("status: expected %0d, actual %0d", exp_r.status, status_i);
            if (exp_r.hit != hit_i)
              $error("hit: expected %0d, actual %0d", exp_r.hit, hit_i);
            if (exp_r.found_start != found_start_i)
              $error("found_start: expected %h, actual %h", exp_r.found_start,
                     found_start_i);
            if (exp_r.found_end != found_end_i)
              $error("found_end: expected %h, actual %h", exp_r.found_end, found_end_i);
            if (exp_r.found_flags != found_flags_i)
              $error("found_flags: expected %0d, actual %0d", exp_r.found_flags,
                     found_flags_i);
            if (exp_r.page_perm != page_perm_i)
              $error("page_perm: expected %0d, actual %0d", exp_r.page_perm, page_perm_i);
            if (exp_r.page_base != page_base_i)
              $error("page_base: expected %h, actual %h", exp_r.page_base, page_base_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_request(req_type_i, addr_i, range_end_i,
                                                   access_flags_i, fault_code_i));
    end
  end
endmodule
`default_nettype wire

>>> verif/vma_region_table_fault_check_test.sv
// Top of the region table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module vma_region_table_fault_check_test import vrt_pkg::*;;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [31:0] addr_i = '0;
  logic [31:0] range_end_i = '0;
  logic [2:0] access_flags_i = '0;
  logic [1:0] fault_code_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic hit_o;
  logic [31:0] found_start_o;
  logic [31:0] found_end_o;
  logic [2:0] found_flags_o;
  logic [2:0] page_perm_o;
  logic [31:0] page_base_o;
  int fail_count;
  int pending;
  int cycle_count = 0;
  int out_wait = 0;
  logic [31:0] region_lo [$];

  always #5 clk_i = ~clk_i;

  vma_region_table_fault_check dut (.*);

  vma_region_table_fault_check_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .addr_i,
    .range_end_i, .access_flags_i, .fault_code_i, .out_valid_i(out_valid_o),
    .out_stall_i, .status_i(status_o), .hit_i(hit_o), .found_start_i(found_start_o),
    .found_end_i(found_end_o), .found_flags_i(found_flags_o), .page_perm_i(page_perm_o),
    .page_base_i(page_base_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // After each result the receiver stalls for a randomly drawn number of cycles, rarely none.
  always @(posedge clk_i) begin : out_side
    int draw;
    if (out_stall_i) begin
      out_wait <= out_wait - 1;
      out_stall_i <= (out_wait > 1);
    end else if (out_valid_o) begin
      draw = $urandom_range(0, 17);
      out_wait <= draw;
      out_stall_i <= (draw != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] req, logic [31:0] a, logic [31:0] e,
                              logic [2:0] f, logic [1:0] code, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    addr_i <= a;
    range_end_i <= e;
    access_flags_i <= f;
    fault_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  // Address near a known region edge so lookups mostly hit or just miss.
  function automatic logic [31:0] near_region();
    logic [31:0] b;
    if (region_lo.size() == 0) return $urandom;
    b = region_lo[$urandom_range(0, region_lo.size() - 1)];
    return b + $urandom_range(0, 32'h3000) - 32'h10;
  endfunction

  // The last transaction is counted by the checker on the edge that accepted it.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] s, e;
    logic [1:0] req;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty table, extremes, overlaps, every fault code and a full table.
    send_request(ReqLookup, 32'h0, '0, '0, '0, 0);
    send_request(ReqFault, 32'hffff_ffff, '0, '0, 2'd3, 0);
    send_request(ReqInsert, 32'h10, 32'h10, 3'd7, '0, 0);
    send_request(ReqInsert, 32'h0, 32'h1000, 3'd1, '0, 0);
    send_request(ReqInsert, 32'hffff_f000, 32'hffff_ffff, 3'd6, '0, 0);
    send_request(ReqInsert, 32'h800, 32'h2000, 3'd2, '0, 0);
    send_request(ReqInsert, 32'h2000, 32'h5000, 3'd2, '0, 0);
    send_request(ReqInsert, 32'h1800, 32'h2800, 3'd0, '0, 0);
    send_request(ReqInsert, 32'h1000, 32'h2000, 3'd4, '0, 0);
    for (int c = 0; c < 4; c++) begin
      send_request(ReqFault, 32'h2abc, '0, '0, c[1:0], 1);
      send_request(ReqFault, 32'hffff_fabc, '0, '0, c[1:0], 0);
      send_request(ReqFault, 32'h0123, '0, '0, c[1:0], 0);
    end
    send_request(ReqLookup, 32'hffff_ffff, '0, '0, '0, 0);
    send_request(ReqLookup, 32'h1fff, '0, '0, '0, 0);
    for (int i = 0; i < 13; i++)
      send_request(ReqInsert, 32'h10000 * (i + 1), 32'h10000 * (i + 1) + 32'h100,
                   i[2:0], '0, 0);
    send_request(ReqInsert, 32'h7000_0000, 32'h7000_1000, 3'd3, '0, 0);
    send_request(ReqInsert, 32'h10, 32'h20, 3'd3, '0, 0);
    send_request(ReqClear, $urandom, $urandom, 3'd7, 2'd3, 0);
    // Hold off until the table is idle before the random part.
    drain();
    // Random: small region inserts mixed with lookups and faults, mostly near known regions.
    for (int k = 0; k < 1560; k++) begin
      n = $urandom_range(0, 99);
      if (n < 2) begin
        req = ReqClear;
        region_lo.delete();
      end else if (n < 30) req = ReqInsert;
      else if (n < 60) req = ReqLookup;
      else req = ReqFault;
      if (req == ReqInsert) begin
        s = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 63)) << 20;
        e = ($urandom_range(0, 9) == 0) ? $urandom : s + $urandom_range(1, 32'h4000);
        if (s < e) region_lo.push_back(s);
      end else begin
        s = ($urandom_range(0, 7) == 0) ? $urandom : near_region();
        e = $urandom;
      end
      send_request(req, s, e, 3'($urandom), 2'($urandom), draw_gap());
      if (k == 800) drain();
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/vrt_pkg.sv
rtl/vrt_table.sv
rtl/vma_region_table_fault_check.sv
verif/vma_region_table_fault_check_checker.sv
verif/vma_region_table_fault_check_test.sv
